/* design/isort_pkg.sv */
package isort_pkg;

    localparam int DATA_W = 32;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

/* design/isort_cell.sv */
module isort_cell
    import isort_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [CW-1:0]            i_count,
    input  logic signed [DATA_W-1:0] i_prev_value,
    input  logic                     i_prev_gt,
    input  logic signed [DATA_W-1:0] i_next_value,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_gt
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     occupied;
    logic                     first_free;
    logic                     take;

    assign occupied   = CW'(IDX) < i_count;
    assign first_free = CW'(IDX) == i_count;
    assign o_gt       = occupied && (r_value > i_value);
    assign take       = o_gt || first_free;
    assign o_value    = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_next_value;
        end else if (i_ctl.ins && take) begin
            n_value = i_prev_gt ? i_prev_value : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* design/insertion_sorter_core.sv */
// channel  direction  handshake                 word
// input    in         start & !busy             i_value, i_end_of_list
// result   out        o_strobe, one cycle only  o_sorted_value, o_last_out, o_overflow
//
// filling: one word accepted per cycle and written into its place in the cell registers by the cell chain
// the word marked end of list is inserted, then the chain drains one result per cycle
// busy stays high while the n held words of a list drain after its last word
// reset clears the count, drop flag and state; cell contents are not reset
// results cannot be stalled; words past CAPACITY are dropped and flagged
module insertion_sorter_core
    import isort_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_end_of_list,
    output logic                     o_strobe,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_left, n_left;
    logic            r_drop, n_drop;
    logic            accept;
    logic            full;
    t_cell_ctl       ctl;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_gt    [CAPACITY];

    assign accept = start && !busy;
    assign full   = r_count == CW'(CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_left  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_drop  <= n_drop;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_drop    = r_drop;
        ctl.ins   = 1'b0;
        ctl.shift = 1'b0;
        busy      = 1'b0;
        o_strobe  = 1'b0;
        case (r_state)
            ST_FILL: begin
                if (accept) begin
                    ctl.ins = !full;
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_end_of_list) begin
                        n_left  = n_count;
                        n_count = '0;
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                busy      = 1'b1;
                o_strobe  = 1'b1;
                ctl.shift = 1'b1;
                n_left    = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_drop  = 1'b0;
                    n_state = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] prev_value;
        logic                     prev_gt;
        logic signed [DATA_W-1:0] next_value;

        if (g == 0) begin : g_head
            assign prev_value = i_value;
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign prev_value = cell_value[g-1];
            assign prev_gt    = cell_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_value = cell_value[g];
        end else begin : g_mid
            assign next_value = cell_value[g+1];
        end

        isort_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_value      (i_value),
            .i_count      (r_count),
            .i_prev_value (prev_value),
            .i_prev_gt    (prev_gt),
            .i_next_value (next_value),
            .o_value      (cell_value[g]),
            .o_gt         (cell_gt[g])
        );
    end

    assign o_sorted_value = cell_value[0];
    assign o_last_out     = o_strobe && (r_left == CW'(1));
    assign o_overflow     = o_strobe && r_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count beyond capacity");

    a_strobe_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_left != '0))
        else $error("result strobed with nothing left to drain");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |=> (!busy && (r_count == '0) && !r_drop))
        else $error("not cleared after final result");

    a_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_list) |=> (o_strobe && (r_count == '0)))
        else $error("end of list did not start drain");

endmodule
